// File: hw/rtl/bitmap_block_allocator_top_defines.svh
// Assertion macros for the bitmap block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/bba_pkg.sv
// Shared constants and types of the bitmap block allocator.
package bba_pkg;

  localparam int WordW     = 64;
  localparam int WordIdxW  = 6;
  localparam int MapAwMax  = 9;
  localparam int SumAwMax  = 3;
  localparam int BlockW    = 15;
  localparam int CountW    = 16;
  localparam int BlockReach = 32768;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_MARK  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic                map_re;
    logic                map_we;
    logic [MapAwMax-1:0] map_addr;
    logic [WordW-1:0]    map_wdata;
    logic                sum_re;
    logic                sum_we;
    logic [SumAwMax-1:0] sum_addr;
    logic [WordW-1:0]    sum_wdata;
  } bba_mem_req_t;

endpackage

// File: hw/rtl/bba_first_zero.sv
// Priority encoder for the lowest clear bit of a map or summary word.
module bba_first_zero import bba_pkg::*; (
  input  logic [WordW-1:0]    word_i,
  output logic                found_o,
  output logic [WordIdxW-1:0] idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        idx_o = WordIdxW'(i);
      end
    end
  end

  assign found_o = ~&word_i;

endmodule

// File: hw/rtl/bba_store.sv
// Bitmap and per-word summary memories, with the clearing sweep after reset.
module bba_store import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 32768
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bba_mem_req_t     req_i,
  output logic [WordW-1:0] map_rdata_o,
  output logic [WordW-1:0] sum_rdata_o,
  output logic             ready_o
);

  localparam int MapBits  = (MAX_BLOCKS < BlockReach) ? MAX_BLOCKS : BlockReach;
  localparam int Words    = (MapBits + WordW - 1) / WordW;
  localparam int SumWords = (Words + WordW - 1) / WordW;
  localparam int WA       = (Words > 1) ? $clog2(Words) : 1;
  localparam int SA       = (SumWords > 1) ? $clog2(SumWords) : 1;

  logic [WordW-1:0] map_mem [Words];
  logic [WordW-1:0] sum_mem [SumWords];
  logic [WordW-1:0] map_rdata_q;
  logic [WordW-1:0] sum_rdata_q;

  logic          clr_q, clr_d;
  logic [WA-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_in_sum;

  assign clr_in_sum = ({1'b0, clr_cnt_q} < (WA + 1)'(SumWords));

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      if (clr_cnt_q == WA'(Words - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      map_mem[clr_cnt_q] <= '0;
    end else if (req_i.map_we) begin
      map_mem[req_i.map_addr[WA-1:0]] <= req_i.map_wdata;
    end
    if (req_i.map_re) begin
      map_rdata_q <= map_mem[req_i.map_addr[WA-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      if (clr_in_sum) begin
        sum_mem[clr_cnt_q[SA-1:0]] <= '0;
      end
    end else if (req_i.sum_we) begin
      sum_mem[req_i.sum_addr[SA-1:0]] <= req_i.sum_wdata;
    end
    if (req_i.sum_re) begin
      sum_rdata_q <= sum_mem[req_i.sum_addr[SA-1:0]];
    end
  end

  assign map_rdata_o = map_rdata_q;
  assign sum_rdata_o = sum_rdata_q;
  assign ready_o     = !clr_q;

endmodule

// File: hw/rtl/bitmap_block_allocator_top.sv
// Top level of the bitmap first-fit block allocator.
// The used-block bitmap sits in a memory of 64-bit words; a second memory holds one
// "word full" bit per map word, 64 to a summary word. Allocate scans the summary
// words from the bottom for the first word that still has a clear bit, reads that
// map word, takes its lowest clear bit and writes back both the map word and its
// summary bit. Free and mark read the map word and its summary word together and
// write both back, when the bit changes, once the output register is free. One
// request is handled at a time. Allocate reads the summary words one after another
// through the single read port of the summary memory, at most
// ceil(ceil(min(MAX_BLOCKS,32768)/64)/64) of them, 8 at the default size.
// Results sit in an output register, so the next request is taken while a result
// still waits. After reset both memories are swept to zero, one map word per cycle,
// ceil(min(MAX_BLOCKS,32768)/64) map words, 512 by default; requests stall until
// the sweep is done, configuration writes are taken at once.
// The free count saturates at zero if total_blocks is lowered below the used count.
`include "bitmap_block_allocator_top_defines.svh"

module bitmap_block_allocator_top import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 32768
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: total_blocks
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [BlockW-1:0] block_number_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BlockW-1:0] allocated_block_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] free_count_o,
  output logic              changed_o
);

  localparam int MapBits  = (MAX_BLOCKS < BlockReach) ? MAX_BLOCKS : BlockReach;
  localparam int Words    = (MapBits + WordW - 1) / WordW;
  localparam int SumWords = (Words + WordW - 1) / WordW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SCHK = 3'd2;
  localparam logic [2:0] S_MRD  = 3'd3;
  localparam logic [2:0] S_MCHK = 3'd4;
  localparam logic [2:0] S_FCHK = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [BlockW-1:0]   blk_q, blk_d;
  logic [SumAwMax-1:0] s_q, s_d;
  logic [MapAwMax-1:0] w_q, w_d;
  logic                full_q, full_d;
  logic [CountW-1:0]   total_q;
  logic [CountW-1:0]   used_q, used_d;

  logic                out_valid_q, out_valid_d;
  logic [BlockW-1:0]   alloc_q, alloc_d;
  logic [1:0]          status_q, status_d;
  logic [CountW-1:0]   free_q, free_d;
  logic                changed_q, changed_d;

  bba_mem_req_t        mreq;
  logic [WordW-1:0]    map_rdata, sum_rdata;
  logic                st_ready;

  logic [WordW-1:0]    fz_word;
  logic                fz_found;
  logic [WordIdxW-1:0] fz_idx;

  logic [CountW-1:0]   eff;
  logic                accept;
  logic                slot_free;
  logic                load_out;
  logic                grant;
  logic                flip;
  logic                in_range;
  logic [MapAwMax-1:0] cand_w;
  logic [BlockW-1:0]   cand_blk;
  logic [MapAwMax-1:0] blk_w;
  logic [WordW-1:0]    new_word;

  // Effective block count: the register, capped at what the map covers.
  assign eff = (total_q < CountW'(MapBits)) ? total_q : CountW'(MapBits);

  assign in_stall_o = (state_q != S_IDLE) || !st_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign blk_w    = blk_q[BlockW-1:WordIdxW];
  assign cand_w   = {s_q, fz_idx};
  assign cand_blk = {w_q, fz_idx};

  // One finder serves the summary scan and the map word search.
  assign fz_word = (state_q == S_SCHK) ? sum_rdata : map_rdata;

  bba_first_zero u_first_zero (
    .word_i  (fz_word),
    .found_o (fz_found),
    .idx_o   (fz_idx)
  );

  bba_store #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mreq),
    .map_rdata_o (map_rdata),
    .sum_rdata_o (sum_rdata),
    .ready_o     (st_ready)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    blk_d       = blk_q;
    s_d         = s_q;
    w_d         = w_q;
    full_d      = full_q;
    used_d      = used_q;
    out_valid_d = out_valid_q;
    alloc_d     = alloc_q;
    status_d    = status_q;
    free_d      = free_q;
    changed_d   = changed_q;
    mreq        = '0;
    load_out    = 1'b0;
    grant       = 1'b0;
    flip        = 1'b0;
    in_range    = 1'b0;
    new_word    = map_rdata;

    // Drop the result once the far side has taken it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = req_type_i;
          blk_d = block_number_i;
          if (req_type_i == REQ_ALLOC) begin
            s_d     = '0;
            full_d  = 1'b0;
            state_d = S_SRD;
          end else begin
            // Fetch the target map word and its summary word together.
            mreq.map_re   = 1'b1;
            mreq.map_addr = block_number_i[BlockW-1:WordIdxW];
            mreq.sum_re   = 1'b1;
            mreq.sum_addr = block_number_i[BlockW-1:BlockW-SumAwMax];
            state_d       = S_FCHK;
          end
        end
      end
      S_SRD: begin
        mreq.sum_re   = 1'b1;
        mreq.sum_addr = s_q;
        state_d       = S_SCHK;
      end
      S_SCHK: begin
        if (fz_found) begin
          if ({1'b0, cand_w} < (MapAwMax + 1)'(Words)) begin
            w_d     = cand_w;
            state_d = S_MRD;
          end else begin
            full_d  = 1'b1;
            state_d = S_MCHK;
          end
        end else if (s_q == SumAwMax'(SumWords - 1)) begin
          full_d  = 1'b1;
          state_d = S_MCHK;
        end else begin
          s_d     = s_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_MRD: begin
        mreq.map_re   = 1'b1;
        mreq.map_addr = w_q;
        state_d       = S_MCHK;
      end
      S_MCHK: begin
        // Hold here with the read data parked until the output register is free.
        if (slot_free) begin
          grant = !full_q && fz_found && ({1'b0, cand_blk} < eff);
          if (grant) begin
            new_word       = map_rdata | (WordW'(1) << fz_idx);
            mreq.map_we    = 1'b1;
            mreq.map_addr  = w_q;
            mreq.map_wdata = new_word;
            mreq.sum_we    = 1'b1;
            mreq.sum_addr  = w_q[MapAwMax-1:WordIdxW];
            mreq.sum_wdata = sum_rdata;
            mreq.sum_wdata[w_q[WordIdxW-1:0]] = &new_word;
            used_d    = used_q + 1'b1;
            alloc_d   = cand_blk;
            status_d  = ST_OK;
            changed_d = 1'b1;
          end else begin
            alloc_d   = '0;
            status_d  = ST_FULL;
            changed_d = 1'b0;
          end
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_FCHK: begin
        if (slot_free) begin
          in_range = ({1'b0, blk_q} < eff);
          flip = in_range &&
                 (((op_q == REQ_FREE) && map_rdata[blk_q[WordIdxW-1:0]]) ||
                  ((op_q == REQ_MARK) && !map_rdata[blk_q[WordIdxW-1:0]]));
          if (flip) begin
            new_word       = map_rdata ^ (WordW'(1) << blk_q[WordIdxW-1:0]);
            mreq.map_we    = 1'b1;
            mreq.map_addr  = blk_w;
            mreq.map_wdata = new_word;
            mreq.sum_we    = 1'b1;
            mreq.sum_addr  = blk_w[MapAwMax-1:WordIdxW];
            mreq.sum_wdata = sum_rdata;
            mreq.sum_wdata[blk_w[WordIdxW-1:0]] = &new_word;
            used_d = (op_q == REQ_FREE) ? used_q - 1'b1 : used_q + 1'b1;
          end
          alloc_d   = '0;
          changed_d = flip;
          status_d  = (((op_q == REQ_FREE) || (op_q == REQ_MARK)) && !in_range) ?
                      ST_RANGE : ST_OK;
          load_out  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Free count reflects the map after this request, saturating at zero.
    if (load_out) begin
      out_valid_d = 1'b1;
      free_d      = (eff > used_d) ? eff - used_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      full_q      <= 1'b0;
      used_q      <= '0;
      total_q     <= CountW'(BlockReach);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      full_q      <= full_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  // Payload and scan position registers need no reset.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    blk_q     <= blk_d;
    s_q       <= s_d;
    w_q       <= w_d;
    alloc_q   <= alloc_d;
    status_q  <= status_d;
    free_q    <= free_d;
    changed_q <= changed_d;
  end

  assign out_valid_o       = out_valid_q;
  assign allocated_block_o = alloc_q;
  assign status_o          = status_q;
  assign free_count_o      = free_q;
  assign changed_o         = changed_q;

  `BBA_ASSERT(a_used_bound, used_q <= CountW'(MapBits), "used count exceeds map size")
  `BBA_ASSERT(a_err_no_change, !out_valid_q || status_q == ST_OK || (!changed_q && alloc_q == '0), "error result flipped a bit")
  `BBA_ASSERT_NEXT(a_grant_counts, grant, used_q == $past(used_q) + 1'b1, "grant did not bump count")
  `BBA_ASSERT(a_idle_no_write, state_q != S_IDLE || (!mreq.map_we && !mreq.sum_we), "memory write while idle")

endmodule

// File: tb/sv/bba_result_checker.sv
// Result checker for the bitmap block allocator: tracks the map and compares every result.
module bba_result_checker import bba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        req_type_i,
  input  logic [BlockW-1:0] block_number_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [BlockW-1:0] allocated_block_i,
  input  logic [1:0]        status_i,
  input  logic [CountW-1:0] free_count_i,
  input  logic              changed_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BlockW-1:0] block;
    logic [1:0]        status;
    logic [CountW-1:0] free;
    logic              changed;
  } grant_t;

  bit          block_used_q [BlockReach];
  logic [15:0] volume_size_q;
  int unsigned used_blocks_q;
  grant_t      grants_q [$];

  // Apply one request to the shadow map and return the result it should give.
  function automatic grant_t apply_request(input logic [1:0] req, input logic [BlockW-1:0] blk);
    grant_t      res;
    int unsigned eff;
    eff = (volume_size_q > BlockReach) ? BlockReach : volume_size_q;
    res = '0;
    res.status = ST_OK;
    case (req)
      REQ_ALLOC: begin
        res.status = ST_FULL;
        for (int unsigned b = 0; b < eff; b++) begin
          if (!block_used_q[b]) begin
            block_used_q[b] = 1'b1;
            used_blocks_q++;
            res.block   = BlockW'(b);
            res.status  = ST_OK;
            res.changed = 1'b1;
            break;
          end
        end
      end
      REQ_FREE, REQ_MARK: begin
        if (blk >= eff) begin
          res.status = ST_RANGE;
        end else if (block_used_q[blk] != (req == REQ_MARK)) begin
          block_used_q[blk] = (req == REQ_MARK);
          if (req == REQ_MARK) used_blocks_q++;
          else used_blocks_q--;
          res.changed = 1'b1;
        end
      end
      default: ;
    endcase
    res.free = (eff > used_blocks_q) ? CountW'(eff - used_blocks_q) : '0;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_used_q  = '{default: 1'b0};
      used_blocks_q = 0;
      volume_size_q = 16'd32768;
      grants_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin : watch
      grant_t want;
      if (cfg_we_i) volume_size_q = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (grants_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count_o++;
        end else begin
          want = grants_q.pop_front();
          check_field("allocated_block", want.block, allocated_block_i);
          check_field("status", want.status, status_i);
          check_field("free_count", want.free, free_count_i);
          check_field("changed", want.changed, changed_i);
        end
      end
      if (in_valid_i && !in_stall_i) grants_q.push_back(apply_request(req_type_i, block_number_i));
      pending_o = grants_q.size();
    end
  end

endmodule

// File: tb/sv/tb_bitmap_block_allocator_top.sv
// Testbench top for the bitmap block allocator: stimulus, idling and verdict.
module tb_bitmap_block_allocator_top import bba_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Request code the block treats as a no-op.
  localparam logic [1:0] REQ_NONE   = 2'd3;
  // Far above the slowest legal run: sweep, worst-case scans, stalls and the long hold.
  localparam int         CycleLimit = 600000;
  localparam int         NumPhases  = 8;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [15:0]       cfg_wdata_i    = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [1:0]        req_type_i     = REQ_ALLOC;
  logic [BlockW-1:0] block_number_i = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [BlockW-1:0] allocated_block_o;
  logic [1:0]        status_o;
  logic [CountW-1:0] free_count_o;
  logic              changed_o;

  int          fail_count;
  int          outstanding;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          long_hold    = 0;
  logic [15:0] volume_size  = 16'd32768;

  // Volume size, sender idling and receiver stalling per random phase.
  int unsigned phase_size [NumPhases] = '{70, 130, 1, 65535, 16, 200, 0, 40};
  int          phase_items[NumPhases] = '{260, 240, 90, 260, 220, 260, 50, 230};
  int          phase_tx   [NumPhases] = '{0, 70, 0, 38, 0, 70, 0, 38};
  int          phase_rx   [NumPhases] = '{0, 0, 70, 38, 0, 0, 70, 38};

  always #2ns clk_i = ~clk_i;

  bitmap_block_allocator_top #(
    .MAX_BLOCKS(32768)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .block_number_i,
    .out_valid_o,
    .out_stall_i,
    .allocated_block_o,
    .status_o,
    .free_count_o,
    .changed_o
  );

  bba_result_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_i        (in_stall_o),
    .req_type_i,
    .block_number_i,
    .out_valid_i       (out_valid_o),
    .out_stall_i,
    .allocated_block_i (allocated_block_o),
    .status_i          (status_o),
    .free_count_i      (free_count_o),
    .changed_i         (changed_o),
    .fail_count_o      (fail_count),
    .pending_o         (outstanding)
  );

  // Receiver: a long hold, once armed, takes precedence over the random stalls.
  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      out_stall_i <= 1'b1;
      long_hold--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Watchdog: give up if the run hangs.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // Drop the request line and hold until every outstanding result has been transferred.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  // Write the volume size only once the block is idle; allow for a worst-case scan.
  task automatic write_volume_size(input logic [15:0] size);
    drain();
    repeat (20) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    volume_size  = size;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Offer one request, idling first at random; entered and left at a falling edge.
  task automatic send_request(input logic [1:0] req, input logic [BlockW-1:0] blk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    block_number_i <= blk;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Mostly valid frees and marks inside a busy low region, plus allocates, edge
  // cases around the volume end and the odd unknown or fully random request.
  task automatic random_request();
    int unsigned eff;
    int unsigned span;
    int          roll;
    int          near;
    logic [1:0]  req;
    logic [BlockW-1:0] blk;
    eff  = (volume_size > BlockReach) ? BlockReach : volume_size;
    span = (eff > 512) ? 256 : eff;
    roll = $urandom_range(0, 99);
    if (roll < 45) req = REQ_ALLOC;
    else if (roll < 70) req = REQ_FREE;
    else if (roll < 92) req = REQ_MARK;
    else if (roll < 96) req = REQ_NONE;
    else req = 2'($urandom_range(0, 3));
    roll = $urandom_range(0, 9);
    if (req == REQ_ALLOC || roll >= 8 || (roll <= 6 && span == 0)) begin
      blk = BlockW'($urandom_range(0, BlockReach - 1));
    end else if (roll <= 6) begin
      blk = BlockW'($urandom_range(0, span - 1));
    end else begin
      // Straddle the last valid block and the first invalid one.
      near = int'(eff) - 2 + int'($urandom_range(0, 3));
      if (near < 0) near = 0;
      if (near > BlockReach - 1) near = BlockReach - 1;
      blk = BlockW'(near);
    end
    send_request(req, blk);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: full-size volume first, requests queue behind the clearing sweep.
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '1);
    send_request(REQ_MARK, BlockW'(BlockReach - 1));   // top block
    send_request(REQ_MARK, BlockW'(BlockReach - 1));   // mark of a used block
    send_request(REQ_FREE, 15'd1);
    send_request(REQ_FREE, 15'd1);                     // free of a free block
    send_request(REQ_ALLOC, 15'h2aaa);
    send_request(REQ_NONE, '1);                        // unknown request type
    send_request(REQ_FREE, BlockW'(BlockReach - 1));
    send_request(REQ_MARK, 15'h5555);
    send_request(REQ_FREE, 15'h2aaa);
    write_volume_size(16'hffff);                       // clamps to the block reach
    send_request(REQ_MARK, '1);
    // Shrink below the used count: free count saturates and high bits stay set.
    write_volume_size(16'd3);
    send_request(REQ_MARK, 15'd2);
    send_request(REQ_ALLOC, '0);                       // volume full
    send_request(REQ_FREE, 15'd5);                     // out of range
    send_request(REQ_MARK, '1);                        // out of range
    send_request(REQ_FREE, '0);
    send_request(REQ_ALLOC, '0);
    write_volume_size(16'd0);                          // empty volume
    send_request(REQ_ALLOC, '1);
    send_request(REQ_FREE, '0);
    send_request(REQ_NONE, '0);
    write_volume_size(16'd32768);
    send_request(REQ_FREE, '1);
    send_request(REQ_FREE, 15'h5555);
    send_request(REQ_FREE, '0);
    send_request(REQ_FREE, 15'd2);

    // Random phases over several volume sizes and idling patterns.
    for (int p = 0; p < NumPhases; p++) begin
      write_volume_size(16'(phase_size[p]));
      tx_idle_pct  = phase_tx[p];
      rx_stall_pct = phase_rx[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 4 && n == 60) begin
          // Hold the receiver off long enough for the block to back up its input.
          @(posedge clk_i);
          long_hold = 400;
          @(negedge clk_i);
        end
        if (p == 4 && n == 150) begin
          drain();
        end
        random_request();
      end
    end
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;

    drain();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_first_zero.sv
hw/rtl/bba_store.sv
hw/rtl/bitmap_block_allocator_top.sv
tb/sv/bba_result_checker.sv
tb/sv/tb_bitmap_block_allocator_top.sv
